### design/tagged_udp_match_and_rewrite_assert.svh
// Assertion macros shared by the tagged UDP match and rewrite block.
`ifndef TAGGED_UDP_MATCH_AND_REWRITE_ASSERT_SVH
`define TAGGED_UDP_MATCH_AND_REWRITE_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked on clk and disabled during reset.
`define TUMR_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("tumr assertion failed");
// Next-cycle implication, checked on clk and disabled during reset.
`define TUMR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("tumr assertion failed");
`else
`define TUMR_ASSERT_IMPL(lbl, pre, post)
`define TUMR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### design/tumr_pkg.sv
// Types, constants and helper functions of the tagged UDP match and rewrite block.
package tumr_pkg;

  localparam int HDR_LEN          = 50;
  localparam int GROUP_SLOTS_DEF  = 16;
  localparam int CHK_LEN          = 14;
  localparam int RW_LEN           = 28;
  localparam int CSUM_W           = 20;
  localparam int CFG_AW           = 3;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_MATCH = 2'd1;
  localparam logic [1:0] OP_FWD   = 2'd2;

  localparam logic [1:0] VERDICT_PASS    = 2'd0;
  localparam logic [1:0] VERDICT_FORWARD = 2'd1;
  localparam logic [1:0] VERDICT_DELIVER = 2'd2;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [3:0]  IHL_PLAIN      = 4'd5;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;

  localparam logic [0:0] REG_TAG_MAGIC = 1'b0;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  slot;
    logic [7:0]  frame_byte;
    logic        frame_last;
    logic [31:0] addr_a;
    logic [15:0] port_a;
    logic [31:0] addr_b;
    logic [15:0] port_b;
    logic [47:0] mac_a;
    logic [47:0] mac_b;
    logic        fwd_enable;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] verdict;
  } out_item_t;

  typedef struct packed {
    logic        en;
    logic [15:0] dst_port;
    logic [15:0] src_port;
    logic [31:0] dst_ip;
    logic [31:0] src_ip;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
  } fwd_t;

  typedef struct packed {
    logic [31:0] group;
    logic [15:0] port;
  } match_t;

  typedef struct packed {
    logic clr;
    logic add;
    logic fold;
  } csum_ctrl_t;

  // Header positions fetched for the qualification check, in shift order.
  localparam logic [5:0] CHK_POS [CHK_LEN] = '{
    6'd12, 6'd13, 6'd14, 6'd23, 6'd42, 6'd43, 6'd44,
    6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd36, 6'd37
  };

  // Header positions overwritten on a forward.
  localparam logic [5:0] RW_POS [RW_LEN] = '{
    6'd0,  6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd6,
    6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd24, 6'd25,
    6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32,
    6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd40, 6'd41
  };

  // Rewritten byte at a header position, big-endian within each field.
  function automatic logic [7:0] rw_byte(input logic [5:0] pos, input fwd_t f,
                                         input logic [15:0] cs);
    logic [7:0] b;
    b = 8'h00;
    case (pos) inside
      [6'd0:6'd5]:   b = f.dst_mac[8*(5 - pos) +: 8];
      [6'd6:6'd11]:  b = f.src_mac[8*(11 - pos) +: 8];
      [6'd24:6'd25]: b = cs[8*(25 - pos) +: 8];
      [6'd26:6'd29]: b = f.src_ip[8*(29 - pos) +: 8];
      [6'd30:6'd33]: b = f.dst_ip[8*(33 - pos) +: 8];
      [6'd34:6'd35]: b = f.src_port[8*(35 - pos) +: 8];
      [6'd36:6'd37]: b = f.dst_port[8*(37 - pos) +: 8];
      default:       b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### design/tumr_ram.sv
// Generic simple dual-port RAM with registered read.
module tumr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/tumr_csum.sv
// Shared accumulator for the IPv4 header checksum: byte adds and end-around folds.
module tumr_csum (
  input  logic                  clk,
  input  tumr_pkg::csum_ctrl_t  ctrl,
  input  logic [7:0]            data,
  input  logic                  hi,
  output logic [15:0]           sum
);
  import tumr_pkg::*;

  logic [CSUM_W-1:0] acc_r;
  logic [CSUM_W-1:0] acc_nxt;
  logic [CSUM_W-1:0] operand;

  always_comb begin
    operand = hi ? CSUM_W'({data, 8'h00}) : CSUM_W'(data);
    acc_nxt = acc_r;
    if (ctrl.clr) begin
      acc_nxt = '0;
    end else if (ctrl.add) begin
      acc_nxt = acc_r + operand;
    end else if (ctrl.fold) begin
      acc_nxt = CSUM_W'(acc_r[15:0]) + CSUM_W'(acc_r[CSUM_W-1:16]);
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign sum = acc_r[15:0];

endmodule

### design/tagged_udp_match_and_rewrite.sv
// Top level of the tagged UDP match and rewrite block.
// Frame bytes arrive one item at a time. The first 50 bytes of a frame are held in a
// header RAM; bytes after that pass straight through with the frame's verdict, one
// item per cycle when the output is not stalled. When the 50th byte is taken a
// sequencer decides the verdict, all through one RAM read port, one compare and one
// checksum adder: it fetches the 14 header bytes it checks, scans up to GROUP_SLOTS
// match slots, reads the forward entry, and on a forward adds 20 header bytes into
// the checksum, folds it twice and makes 28 rewrite writes. The held bytes then leave
// one at a time, each read from the header RAM before it is sent. A frame that ends
// before 50 bytes is released unchanged with verdict pass. Table writes (match and
// forward slots) give no item; a slot at or beyond GROUP_SLOTS is ignored. The block
// takes no input while the sequencer runs or while a result waits on a stalled output.
// tag_magic sits at byte address 0 of the APB port and resets to zero.
`include "tagged_udp_match_and_rewrite_assert.svh"
module tagged_udp_match_and_rewrite #(
  parameter int GROUP_SLOTS = tumr_pkg::GROUP_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tumr_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tumr_pkg::out_item_t           out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tumr_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tumr_pkg::*;

  localparam int SW = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int CW = $clog2(GROUP_SLOTS + 1);
  localparam int HAW = $clog2(HDR_LEN);

  typedef enum logic [14:0] {
    ST_IDLE     = 15'b000000000000001,
    ST_CHK_RD   = 15'b000000000000010,
    ST_CHK_LD   = 15'b000000000000100,
    ST_EVAL     = 15'b000000000001000,
    ST_SCAN_RD  = 15'b000000000010000,
    ST_SCAN_CMP = 15'b000000000100000,
    ST_FWD_RD   = 15'b000000001000000,
    ST_FWD_CHK  = 15'b000000010000000,
    ST_CS_RD    = 15'b000000100000000,
    ST_CS_ADD   = 15'b000001000000000,
    ST_FOLD1    = 15'b000010000000000,
    ST_FOLD2    = 15'b000100000000000,
    ST_WR       = 15'b001000000000000,
    ST_REL_RD   = 15'b010000000000000,
    ST_REL_LD   = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Frame bookkeeping.
  logic [5:0]   cnt_r, cnt_nxt;
  logic [1:0]   verdict_r, verdict_nxt;
  logic         last_r, last_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [CW-1:0] s_r, s_nxt;
  logic [8*CHK_LEN-1:0] fld_r, fld_nxt;
  fwd_t         fwd_r, fwd_nxt;
  logic [31:0]  magic_r;

  // Output register.
  logic         out_valid_r, out_valid_nxt;
  out_item_t    out_r, out_nxt;

  // Table valid bits: a slot never written reads as all zero.
  logic [GROUP_SLOTS-1:0] mt_valid_r, fw_valid_r;

  // Header RAM controls.
  logic           hdr_we, hdr_re;
  logic [HAW-1:0] hdr_waddr, hdr_raddr;
  logic [7:0]     hdr_wdata, hdr_rdata;

  // Table RAM controls.
  logic          mt_we, mt_re, fw_we, fw_re;
  logic [SW-1:0] slot_idx, scan_idx;
  match_t        mt_wdata, mt_rdata;
  fwd_t          fw_wdata, fw_rdata;

  // Checksum unit.
  csum_ctrl_t   cs_ctrl;
  logic [7:0]   cs_data;
  logic         cs_hi;
  logic [15:0]  cs_sum;

  logic         in_acc, out_free, slot_ok, tag_ok, hit, rel_end;
  logic [6:0]   slot_ext;
  logic [5:0]   rw_pos;
  fwd_t         fwd_sel;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;

  assign slot_ext = {3'b000, in_data.slot};
  assign slot_ok  = slot_ext < 7'(GROUP_SLOTS);
  assign slot_idx = SW'(slot_ext);
  assign scan_idx = s_r[SW-1:0];

  // The check bytes shift in as: EtherType, version/IHL, protocol, tag word,
  // tag group, then the UDP destination port.
  assign tag_ok = (fld_r[111:96] == ETHERTYPE_IPV4) && (fld_r[91:88] == IHL_PLAIN) &&
                  (fld_r[87:80] == PROTO_UDP) && (fld_r[79:48] == magic_r);
  assign hit = mt_valid_r[scan_idx] && (mt_rdata.group != 32'd0) &&
               (mt_rdata.group == fld_r[47:16]) && (mt_rdata.port == fld_r[15:0]);
  assign fwd_sel = fw_valid_r[scan_idx] ? fw_rdata : '0;
  assign rw_pos  = RW_POS[pos_r[4:0]];
  assign rel_end = (pos_r + 6'd1) == cnt_r;

  assign mt_wdata = '{group: in_data.addr_a, port: in_data.port_a};
  assign fw_wdata = '{en: in_data.fwd_enable, dst_port: in_data.port_a,
                      src_port: in_data.port_b, dst_ip: in_data.addr_a,
                      src_ip: in_data.addr_b, dst_mac: in_data.mac_a,
                      src_mac: in_data.mac_b};

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    verdict_nxt   = verdict_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    s_nxt         = s_r;
    fld_nxt       = fld_r;
    fwd_nxt       = fwd_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    hdr_we        = 1'b0;
    hdr_re        = 1'b0;
    hdr_waddr     = HAW'(cnt_r);
    hdr_raddr     = HAW'(pos_r);
    hdr_wdata     = in_data.frame_byte;
    mt_we         = 1'b0;
    mt_re         = 1'b0;
    fw_we         = 1'b0;
    fw_re         = 1'b0;
    cs_ctrl       = '0;
    cs_data       = hdr_rdata;
    cs_hi         = !pos_r[0];

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.opcode)
            OP_MATCH: mt_we = slot_ok;
            OP_FWD:   fw_we = slot_ok;
            OP_FRAME: begin
              if (cnt_r == 6'(HDR_LEN)) begin
                // Header already released: pass the byte straight through.
                out_nxt       = '{out_byte: in_data.frame_byte,
                                  out_last: in_data.frame_last, verdict: verdict_r};
                out_valid_nxt = 1'b1;
                if (in_data.frame_last) begin
                  cnt_nxt     = '0;
                  verdict_nxt = VERDICT_PASS;
                end
              end else begin
                hdr_we   = 1'b1;
                cnt_nxt  = cnt_r + 6'd1;
                last_nxt = in_data.frame_last;
                pos_nxt  = '0;
                if (cnt_r == 6'(HDR_LEN - 1)) begin
                  state_nxt = ST_CHK_RD;
                end else if (in_data.frame_last) begin
                  state_nxt = ST_REL_RD;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_CHK_RD: begin
        hdr_re    = 1'b1;
        hdr_raddr = HAW'(CHK_POS[pos_r[3:0]]);
        state_nxt = ST_CHK_LD;
      end
      ST_CHK_LD: begin
        fld_nxt = {fld_r[8*CHK_LEN-9:0], hdr_rdata};
        if (pos_r == 6'(CHK_LEN - 1)) begin
          state_nxt = ST_EVAL;
        end else begin
          pos_nxt   = pos_r + 6'd1;
          state_nxt = ST_CHK_RD;
        end
      end
      ST_EVAL: begin
        s_nxt   = '0;
        pos_nxt = '0;
        if (tag_ok) begin
          state_nxt = ST_SCAN_RD;
        end else begin
          verdict_nxt = VERDICT_PASS;
          state_nxt   = ST_REL_RD;
        end
      end
      ST_SCAN_RD: begin
        mt_re     = 1'b1;
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (hit) begin
          state_nxt = ST_FWD_RD;
        end else if ((s_r + CW'(1)) == CW'(GROUP_SLOTS)) begin
          verdict_nxt = VERDICT_PASS;
          state_nxt   = ST_REL_RD;
        end else begin
          s_nxt     = s_r + CW'(1);
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_FWD_RD: begin
        fw_re     = 1'b1;
        state_nxt = ST_FWD_CHK;
      end
      ST_FWD_CHK: begin
        fwd_nxt = fwd_sel;
        if (!fwd_sel.en) begin
          verdict_nxt = VERDICT_DELIVER;
          state_nxt   = ST_REL_RD;
        end else begin
          cs_ctrl.clr = 1'b1;
          pos_nxt     = 6'd14;
          state_nxt   = ST_CS_RD;
        end
      end
      ST_CS_RD: begin
        hdr_re    = 1'b1;
        state_nxt = ST_CS_ADD;
      end
      ST_CS_ADD: begin
        // Bytes below the checksum field come from the RAM, the rest from the
        // new addresses with the checksum field taken as zero.
        cs_ctrl.add = 1'b1;
        cs_data     = (pos_r < 6'd24) ? hdr_rdata : rw_byte(pos_r, fwd_r, 16'h0000);
        if (pos_r == 6'd33) begin
          state_nxt = ST_FOLD1;
        end else begin
          pos_nxt   = pos_r + 6'd1;
          state_nxt = ST_CS_RD;
        end
      end
      ST_FOLD1: begin
        cs_ctrl.fold = 1'b1;
        state_nxt    = ST_FOLD2;
      end
      ST_FOLD2: begin
        cs_ctrl.fold = 1'b1;
        pos_nxt      = '0;
        state_nxt    = ST_WR;
      end
      ST_WR: begin
        hdr_we    = 1'b1;
        hdr_waddr = HAW'(rw_pos);
        hdr_wdata = rw_byte(rw_pos, fwd_r, ~cs_sum);
        if (pos_r == 6'(RW_LEN - 1)) begin
          verdict_nxt = VERDICT_FORWARD;
          pos_nxt     = '0;
          state_nxt   = ST_REL_RD;
        end else begin
          pos_nxt = pos_r + 6'd1;
        end
      end
      ST_REL_RD: begin
        hdr_re    = 1'b1;
        state_nxt = ST_REL_LD;
      end
      ST_REL_LD: begin
        if (out_free) begin
          out_nxt       = '{out_byte: hdr_rdata, out_last: rel_end && last_r,
                            verdict: verdict_r};
          out_valid_nxt = 1'b1;
          if (rel_end) begin
            if (last_r) begin
              cnt_nxt     = '0;
              verdict_nxt = VERDICT_PASS;
            end
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt   = pos_r + 6'd1;
            state_nxt = ST_REL_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      verdict_r   <= VERDICT_PASS;
      out_valid_r <= 1'b0;
      mt_valid_r  <= '0;
      fw_valid_r  <= '0;
      magic_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      verdict_r   <= verdict_nxt;
      out_valid_r <= out_valid_nxt;
      if (mt_we) begin
        mt_valid_r[slot_idx] <= 1'b1;
      end
      if (fw_we) begin
        fw_valid_r[slot_idx] <= 1'b1;
      end
      if (psel && penable && pwrite && (paddr[2] == REG_TAG_MAGIC)) begin
        magic_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r <= last_nxt;
    pos_r  <= pos_nxt;
    s_r    <= s_nxt;
    fld_r  <= fld_nxt;
    fwd_r  <= fwd_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_TAG_MAGIC) ? magic_r : 32'd0;

  tumr_ram #(.WIDTH(8), .DEPTH(HDR_LEN)) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hdr_waddr),
    .wdata (hdr_wdata),
    .re    (hdr_re),
    .raddr (hdr_raddr),
    .rdata (hdr_rdata)
  );

  tumr_ram #(.WIDTH($bits(match_t)), .DEPTH(GROUP_SLOTS)) u_match_ram (
    .clk   (clk),
    .we    (mt_we),
    .waddr (slot_idx),
    .wdata (mt_wdata),
    .re    (mt_re),
    .raddr (scan_idx),
    .rdata (mt_rdata)
  );

  tumr_ram #(.WIDTH($bits(fwd_t)), .DEPTH(GROUP_SLOTS)) u_fwd_ram (
    .clk   (clk),
    .we    (fw_we),
    .waddr (slot_idx),
    .wdata (fw_wdata),
    .re    (fw_re),
    .raddr (scan_idx),
    .rdata (fw_rdata)
  );

  tumr_csum u_csum (
    .clk  (clk),
    .ctrl (cs_ctrl),
    .data (cs_data),
    .hi   (cs_hi),
    .sum  (cs_sum)
  );

  // The held-byte count never runs past the header length.
  `TUMR_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= 6'(HDR_LEN))
  // A new result appears only from the pass-through path or the release step.
  `TUMR_ASSERT_IMPL(a_out_src, $rose(out_valid_r), $past(state_r == ST_IDLE) || $past(state_r == ST_REL_LD))
  // The rewrite pass always ends in a forward release.
  `TUMR_ASSERT_NEXT(a_wr_fwd, (state_r == ST_WR) && (pos_r == 6'(RW_LEN - 1)), (verdict_r == VERDICT_FORWARD) && (state_r == ST_REL_RD))

endmodule
